/* src/mts_pkg.sv */
// Package for the min-tracking stack: widths, command codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package mts_pkg;

   // default stack depth, handed down from the top level
   localparam int STACK_DEPTH_DEF = 256;

   // value and stored entry widths (encoded entries need two extra bits)
   localparam int DATA_W  = 32;
   localparam int ENTRY_W = 34;

   // command codes on req_cmd
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic do_push;    // push accepted word, stack not full
      logic do_pop;     // pop accepted, stack not empty
      logic set_err;    // accepted command, error flag value loaded
      logic err_val;
      logic rd_issue;   // read the entry below the current top
      logic load_top;   // load top entry register from RAM read data
      logic load_rsp;   // capture result word into output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_empty;
      logic is_full;
      logic has_two;    // at least two entries on the stack
   } dp_status_type;

endpackage

/* src/mts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mts_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mts_ctrl.sv */
// Controller state machine for the min-tracking stack: handshakes, command
// sequencing and the result valid flag. Depends on mts_pkg.
module mts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  mts_pkg::dp_status_type status,
   output mts_pkg::ctrl_cmd_type  cmd
);
   import mts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // state and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.set_err = 1'b1;
               state_in    = ST_EMIT;
               if (req_cmd == CMD_PUSH) begin
                  cmd.err_val = status.is_full;
                  cmd.do_push = !status.is_full;
               end else begin
                  cmd.err_val = status.is_empty;
                  cmd.do_pop  = !status.is_empty;
                  // new top lives in RAM: fetch it before reporting
                  if (status.has_two) begin
                     cmd.rd_issue = 1'b1;
                     state_in     = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            cmd.load_top = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/mts_datapath.sv */
// Datapath for the min-tracking stack: count, minimum, cached top entry,
// entry RAM, encode/decode arithmetic and the result register.
// Depends on mts_pkg and mts_ram.
module mts_datapath #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mts_pkg::ctrl_cmd_type                cmd,
   output mts_pkg::dp_status_type               status,
   input  logic signed [mts_pkg::DATA_W-1:0]    req_push_value,
   output logic signed [mts_pkg::DATA_W-1:0]    rsp_top_value,
   output logic signed [mts_pkg::DATA_W-1:0]    rsp_min_value,
   output logic [$clog2(STACK_DEPTH+1)-1:0]     rsp_entry_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_op_error
);
   import mts_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0]             count_ff, count_in;
   logic signed [DATA_W-1:0]  min_ff, min_in;
   logic signed [ENTRY_W-1:0] top_ff, top_in;
   logic                      err_ff;

   logic signed [DATA_W-1:0]  rsp_top_ff, rsp_min_ff;
   logic [CW-1:0]             rsp_count_ff;
   logic                      rsp_empty_ff, rsp_err_ff;

   logic signed [ENTRY_W-1:0] push_ext, min_ext, push_enc;
   logic [DATA_W-1:0]         min_restore;
   logic [CW-1:0]             count_m2;
   logic [ENTRY_W-1:0]        rd_data;
   logic signed [DATA_W-1:0]  top_dec;

   // status to controller
   assign status.is_empty = (count_ff == '0);
   assign status.is_full  = (count_ff == CW'(STACK_DEPTH));
   assign status.has_two  = (count_ff >= CW'(2));

   // push encoding: value below minimum stored as 2*val - min
   assign push_ext = ENTRY_W'(req_push_value);
   assign min_ext  = ENTRY_W'(min_ff);
   always_comb begin
      if (status.is_empty || (push_ext >= min_ext)) begin
         push_enc = push_ext;
      end else begin
         push_enc = (push_ext <<< 1) - min_ext;
      end
   end

   // pop restore of the previous minimum, 2*min - entry, low bits only
   assign min_restore = {min_ff[DATA_W-2:0], 1'b0} - top_ff[DATA_W-1:0];

   // count, minimum and top entry; the commands exclude each other
   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      top_in   = top_ff;
      if (cmd.do_push) begin
         count_in = count_ff + CW'(1);
         top_in   = push_enc;
         if (status.is_empty || (push_ext < min_ext)) begin
            min_in = req_push_value;
         end
      end else if (cmd.do_pop) begin
         count_in = count_ff - CW'(1);
         if (top_ff < min_ext) begin
            min_in = min_restore;
         end
      end else if (cmd.load_top) begin
         top_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (cmd.set_err) begin
         err_ff <= cmd.err_val;
      end
   end

   // entry store: every pushed entry is written at the current count
   assign count_m2 = count_ff - CW'(2);

   mts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.do_push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (push_enc),
      .rd_en   (cmd.rd_issue),
      .rd_addr (count_m2[AW-1:0]),
      .rd_data (rd_data)
   );

   // decoded top: entry below the minimum stands for the minimum
   assign top_dec = (top_ff < min_ext) ? min_ff : top_ff[DATA_W-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_top_ff   <= status.is_empty ? '0 : top_dec;
         rsp_min_ff   <= status.is_empty ? '0 : min_ff;
         rsp_count_ff <= count_ff;
         rsp_empty_ff <= status.is_empty;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_top_value   = rsp_top_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_op_error    = rsp_err_ff;

endmodule

/* src/min_tracking_stack.sv */
// Min-tracking stack: an accepted push moves to the EMIT state, which loads
// the result register and sets rsp_valid; a pop that must fetch the new top
// through the entry RAM's registered read port passes through LOAD first.
// Words are taken only in the idle state. A new word is accepted while
// the previous result waits; the one after that waits until the held
// result leaves. Reset (synchronous) clears count, minimum and the
// handshake state; the entry RAM is not cleared and holds no valid bits.
module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic signed [mts_pkg::DATA_W-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [mts_pkg::DATA_W-1:0] rsp_top_value,
   output logic signed [mts_pkg::DATA_W-1:0] rsp_min_value,
   output logic [$clog2(STACK_DEPTH+1)-1:0]  rsp_entry_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_op_error
);
   import mts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mts_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_push_value  (req_push_value),
      .rsp_top_value   (rsp_top_value),
      .rsp_min_value   (rsp_min_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_op_error    (rsp_op_error)
   );

endmodule

/* dv/tb.sv */
// Testbench for min_tracking_stack: directed and random push/pop words, a
// shadow stack that predicts every status word, and randomized handshakes.
// Depends on mts_pkg and the min_tracking_stack RTL.
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH      = mts_pkg::STACK_DEPTH_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_LEN   = 300;
   localparam int RAND_WORDS = 1300;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic              cmd;
      logic signed [31:0] push_value;
   } stack_word_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic signed [31:0] min_value;
      logic [8:0]         entry_count;
      logic               is_empty;
      logic               op_error;
   } status_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = mts_pkg::CMD_PUSH;
   logic signed [31:0]  req_push_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_top_value;
   logic signed [31:0]  rsp_min_value;
   logic [8:0]          rsp_entry_count;
   logic                rsp_is_empty;
   logic                rsp_op_error;

   // stimulus and scoreboard
   stack_word_type  cmd_q[$];
   status_word_type status_q[$];
   int          total_words = 0;
   int          taken_cnt = 0;
   int          fail_cnt = 0;
   int          gen_depth = 0;
   logic        req_took = 1'b0;

   // handshake shaping
   logic calm = 1'b0;
   int   calm_left = 0;
   logic hold_off = 1'b0;

   // shadow stack state
   logic signed [33:0] shadow_entries [DEPTH];
   int                 shadow_depth = 0;
   logic signed [31:0] shadow_min = '0;

   min_tracking_stack #(
      .STACK_DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_op_error   (rsp_op_error)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Expected status after one accepted word; updates the shadow stack.
   // Entries below the minimum encode 2*val - old_min.
   function automatic status_word_type predict_status(stack_word_type w);
      status_word_type s;
      longint  v, m, e, t;
      s = '0;
      m = shadow_min;
      if (w.cmd == mts_pkg::CMD_PUSH) begin
         v = $signed(w.push_value);
         if (shadow_depth == DEPTH) begin
            s.op_error = 1'b1;
         end else begin
            if (shadow_depth == 0 || v >= m) begin
               shadow_entries[shadow_depth] = v[33:0];
               if (shadow_depth == 0) shadow_min = v[31:0];
            end else begin
               e = 2 * v - m;
               shadow_entries[shadow_depth] = e[33:0];
               shadow_min = v[31:0];
            end
            shadow_depth++;
         end
      end else if (shadow_depth == 0) begin
         s.op_error = 1'b1;
      end else begin
         // popping an encoded entry brings back the previous minimum
         e = shadow_entries[shadow_depth - 1];
         if (e < m) begin
            t = 2 * m - e;
            shadow_min = t[31:0];
         end
         shadow_depth--;
      end
      if (shadow_depth != 0) begin
         e = shadow_entries[shadow_depth - 1];
         m = shadow_min;
         t = (e < m) ? m : e;
         s.top_value = t[31:0];
         s.min_value = shadow_min;
      end
      s.entry_count = 9'(shadow_depth);
      s.is_empty    = (shadow_depth == 0);
      return s;
   endfunction

   // Idle length: mostly none, some short, a few long; none in calm stretches.
   function automatic int pick_idle();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] rand_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 4))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      if (r < 45) return $signed(32'($urandom_range(0, 32))) - 32'sd16;
      return $signed($urandom);
   endfunction

   task automatic add_word(input logic cmd, input logic signed [31:0] value);
      cmd_q.push_back('{cmd: cmd, push_value: value});
      total_words++;
      if (cmd == mts_pkg::CMD_PUSH) begin
         if (gen_depth < DEPTH) gen_depth++;
      end else if (gen_depth > 0) begin
         gen_depth--;
      end
   endtask

   // Push until full, try a few pushes past full, then drain past empty.
   task automatic fill_and_drain();
      while (gen_depth < DEPTH) add_word(mts_pkg::CMD_PUSH, rand_value());
      repeat ($urandom_range(1, 3)) add_word(mts_pkg::CMD_PUSH, rand_value());
      while (gen_depth > 0) add_word(mts_pkg::CMD_POP, rand_value());
      repeat ($urandom_range(1, 2)) add_word(mts_pkg::CMD_POP, rand_value());
   endtask

   // Falling values build chains of encoded entries, then unwind them.
   task automatic dive();
      longint v;
      int     n;
      n = $urandom_range(4, 20);
      v = $signed(rand_value());
      repeat (n) begin
         add_word(mts_pkg::CMD_PUSH, v[31:0]);
         if ($urandom_range(0, 3) == 0) v = v - longint'($urandom);
         else v = v - $urandom_range(0, 4);
         if (v < longint'(VAL_MIN)) v = VAL_MIN;
      end
      repeat ($urandom_range(n / 2, n + 2)) add_word(mts_pkg::CMD_POP, rand_value());
   endtask

   task automatic random_walk();
      repeat ($urandom_range(10, 40)) begin
         if ($urandom_range(0, 99) < 55) add_word(mts_pkg::CMD_PUSH, rand_value());
         else add_word(mts_pkg::CMD_POP, rand_value());
      end
   endtask

   // Stimulus, one pressure hold-off on the result side, and the end of run.
   initial begin
      // directed: empty pop, extreme values, ties, encoded entries, drain
      add_word(mts_pkg::CMD_POP, '0);
      add_word(mts_pkg::CMD_PUSH, VAL_MAX);
      add_word(mts_pkg::CMD_PUSH, VAL_MIN);
      add_word(mts_pkg::CMD_PUSH, VAL_MIN);
      add_word(mts_pkg::CMD_PUSH, 32'sd0);
      repeat (4) add_word(mts_pkg::CMD_POP, VAL_MAX);
      add_word(mts_pkg::CMD_POP, VAL_MIN);
      add_word(mts_pkg::CMD_PUSH, VAL_MIN);
      add_word(mts_pkg::CMD_PUSH, VAL_MAX);
      repeat (2) add_word(mts_pkg::CMD_POP, '0);
      add_word(mts_pkg::CMD_PUSH, -32'sd1);
      add_word(mts_pkg::CMD_PUSH, 32'sd5);
      add_word(mts_pkg::CMD_PUSH, -32'sd7);
      add_word(mts_pkg::CMD_PUSH, -32'sd7);
      add_word(mts_pkg::CMD_PUSH, -32'sd8);
      repeat (6) add_word(mts_pkg::CMD_POP, '0);

      // random: one forced full/empty cycle, then mixed sequences
      fill_and_drain();
      while (total_words < RAND_WORDS) begin
         case ($urandom_range(0, 9))
            0: begin
               // a full cycle only while it still fits the word budget
               if (total_words + 2 * DEPTH + 8 < RAND_WORDS) fill_and_drain();
               else random_walk();
            end
            1, 2, 3: dive();
            9: begin
               repeat ($urandom_range(5, 15)) add_word(1'($urandom), $signed($urandom));
            end
            default: random_walk();
         endcase
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // long receiver hold-off while the sender keeps offering
      while (taken_cnt < HOLD_AFTER) @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_LEN) @(negedge clock);
      hold_off <= 1'b0;

      while (taken_cnt < total_words) @(negedge clock);
      while (status_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_cnt == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Calm stretches: neither side idles while calm is set.
   always @(negedge clock) begin
      if (calm_left == 0) begin
         calm      <= ($urandom_range(0, 3) == 0);
         calm_left <= $urandom_range(20, 120);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // Command driver: holds a stalled word, otherwise sends the next one
   // after a random gap.
   int gap_left = 0;
   always @(negedge clock) begin
      stack_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (cmd_q.size() != 0) begin
         w = cmd_q.pop_front();
         req_cmd        <= w.cmd;
         req_push_value <= w.push_value;
         req_valid      <= 1'b1;
         gap_left = pick_idle();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result-side stall generator.
   int stall_left = 0;
   always @(negedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         n = pick_idle();
         rsp_stall <= (n != 0);
         stall_left = (n != 0) ? n - 1 : 0;
      end
   end

   task automatic note_failure(input string msg);
      if (fail_cnt < 10) $display("%t MISMATCH %s", $realtime, msg);
      fail_cnt++;
   endtask

   // Monitor: checks each accepted status word, predicts each accepted command.
   always @(posedge clock) begin
      status_word_type got, want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_top_value, rsp_min_value, rsp_entry_count,
                    rsp_is_empty, rsp_op_error};
            if (status_q.size() == 0) begin
               note_failure($sformatf("unexpected word top=%0d min=%0d cnt=%0d",
                                      got.top_value, got.min_value, got.entry_count));
            end else begin
               want = status_q.pop_front();
               if (got.top_value !== want.top_value || got.min_value !== want.min_value ||
                   got.entry_count !== want.entry_count ||
                   got.is_empty !== want.is_empty || got.op_error !== want.op_error) begin
                  note_failure({
                     $sformatf("exp top=%0d min=%0d cnt=%0d empty=%0b err=%0b, ",
                               want.top_value, want.min_value, want.entry_count,
                               want.is_empty, want.op_error),
                     $sformatf("got top=%0d min=%0d cnt=%0d empty=%0b err=%0b",
                               got.top_value, got.min_value, got.entry_count,
                               got.is_empty, got.op_error)});
               end
            end
         end
         if (req_valid && !req_stall) begin
            status_q.push_back(predict_status('{cmd: req_cmd, push_value: req_push_value}));
            taken_cnt++;
         end
      end
   end

   // Watchdog: too long without any word moving on either side.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles < IDLE_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

/* files.f */
src/mts_pkg.sv
src/mts_ram.sv
src/mts_ctrl.sv
src/mts_datapath.sv
src/min_tracking_stack.sv
dv/tb.sv
